// ===== rtl/fheat_pkg.sv =====
// Package for the explicit heat-conduction step engine.
// Holds command and status codes, control structs and the packed-slot helper.
// No dependencies.
package fheat_pkg;

	localparam logic [2:0] CMD_LOAD_NODE  = 3'd0;
	localparam logic [2:0] CMD_LOAD_STIFF = 3'd1;
	localparam logic [2:0] CMD_DIFFUSE    = 3'd2;
	localparam logic [2:0] CMD_ADVANCE    = 3'd3;
	localparam logic [2:0] CMD_READ       = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ZERO_MASS = 2'd1;
	localparam logic [1:0] ST_SAT       = 2'd2;

	localparam int          PACKED_WORDS    = 36;
	localparam int          DIV_W           = 80;
	localparam logic [31:0] TIME_STEP_RESET = 32'd65536;

	// Start of each row of the packed upper triangle.
	localparam logic [5:0] ROW_BASE [8] = '{6'd0, 6'd8, 6'd15, 6'd21,
		6'd26, 6'd30, 6'd33, 6'd35};

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Packed slot of a symmetric entry; (c,r) shares the slot of (r,c).
	function automatic logic [5:0] packed_slot(input logic [2:0] r, input logic [2:0] c);
		logic [2:0] lo;
		logic [2:0] hi;
		lo = (r > c) ? c : r;
		hi = (r > c) ? r : c;
		return ROW_BASE[lo] + {3'd0, hi - lo};
	endfunction

endpackage

// ===== rtl/fheat_if.sv =====
// Channel interfaces for the heat step engine: command words in, result words out.
// Each carries valid, ready and the payload; no package dependency.
interface fheat_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [11:0] node;
	logic [11:0] peer_node;
	logic [9:0]  element;
	logic [2:0]  local_row;
	logic [2:0]  local_col;
	logic signed [31:0] value;
	logic [30:0] mass_value;

	modport source(output valid, cmd, node, peer_node, element, local_row, local_col,
		value, mass_value, input ready);
	modport sink(input valid, cmd, node, peer_node, element, local_row, local_col,
		value, mass_value, output ready);
endinterface

interface fheat_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] temperature;
	logic signed [47:0] force_value;
	logic [30:0] mass_out;
	logic [1:0]  status;

	modport source(output valid, temperature, force_value, mass_out, status, input ready);
	modport sink(input valid, temperature, force_value, mass_out, status, output ready);
endinterface

// ===== rtl/fheat_div.sv =====
// Restoring divider, one quotient bit per cycle, for the advance update.
// Depends on fheat_pkg for the width and the control structs.
module fheat_div
	import fheat_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctrl_t        ctrl,
	input  logic [DIV_W-1:0] dividend,
	input  logic [30:0]      divisor,
	output div_stat_t        stat,
	output logic [DIV_W-1:0] quotient
);
	localparam int CW = $clog2(DIV_W);

	logic [DIV_W-1:0] num_q;
	logic [30:0]      den_q;
	logic [30:0]      rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [31:0]      rem_shift;
	logic             qbit;

	// Trial subtraction of one step.
	always_comb begin
		rem_shift = {rem_q, num_q[DIV_W-1]};
		qbit = rem_shift >= {1'b0, den_q};
	end

	// Quotient bits shift into the dividend register as it empties.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				num_q <= dividend;
				den_q <= divisor;
				rem_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= qbit ? 31'(rem_shift - {1'b0, den_q}) : rem_shift[30:0];
				num_q <= {num_q[DIV_W-2:0], qbit};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = num_q;
endmodule

// ===== rtl/fheat_stiff_store.sv =====
// Element conductivity store: 36 packed words per element, one synchronous port.
// Depends on fheat_pkg for the packed-slot function.
module fheat_stiff_store
	import fheat_pkg::*;
#(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic        clk,
	input  logic        we,
	input  logic        re,
	input  logic [9:0]  element,
	input  logic [2:0]  local_row,
	input  logic [2:0]  local_col,
	input  logic [31:0] wdata,
	output logic [31:0] rdata
);
	localparam int DEPTH = MAX_ELEMENTS * PACKED_WORDS;
	localparam int AW = $clog2(DEPTH);

	logic [31:0] mem [DEPTH];
	logic [AW-1:0] addr;

	// Word address of the entry within the element's block.
	assign addr = AW'(32'(element) * PACKED_WORDS + 32'(packed_slot(local_row, local_col)));

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

// ===== rtl/explicit_fem_heat_step.sv =====
// Explicit heat step engine. Commands are taken one at a time: loads write at acceptance;
// read goes through a memory read to the output register; diffuse through stiffness and
// peer temperature read, multiply, force read-modify-write; advance through read, a 32x48
// multiply in two halves, an 80-bit bit-serial divide and write-back. Node state sits in
// two memories (temperature with mass, and force); stiffness in a third. A result waiting
// in the output register does not stop new commands, only the next result.
module explicit_fem_heat_step
	import fheat_pkg::*;
#(
	parameter int MAX_NODES    = 4096,
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	fheat_in_if.sink    items,
	fheat_out_if.source results
);
	localparam int NAW = $clog2(MAX_NODES);

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_ACC, S_MUL1, S_MUL2, S_DIVS, S_DIV, S_FIN
	} state_t;

	state_t state_q;
	logic [31:0] dt_q;
	logic [2:0]  cmd_q;
	logic        ok_q;
	logic [NAW-1:0] node_q;

	logic [62:0] tm_mem [MAX_NODES];
	logic [47:0] f_mem [MAX_NODES];
	logic signed [31:0] t_rd;
	logic [30:0] m_rd;
	logic [47:0] f_rd;
	logic [31:0] k_rd;

	logic signed [63:0] prod_q;
	logic [47:0] mag_q;
	logic [55:0] plo_q;
	logic [DIV_W-1:0] p_q;

	logic        acc, out_free, out_load;
	logic        node_ok, peer_ok, elem_ok;
	logic [NAW-1:0] node_a, peer_a, tm_ra;
	logic        tm_we, f_we;
	logic [NAW-1:0] tm_wa, f_wa;
	logic [62:0] tm_wd;
	logic [47:0] f_wd;

	div_ctrl_t   dctl;
	div_stat_t   dstat;
	logic [DIV_W-1:0] quo;

	logic signed [63:0] rnd;
	logic signed [48:0] fsum;
	logic [47:0] f_new;
	logic [33:0] qs;
	logic signed [34:0] tsum;
	logic [31:0] t_new;
	logic        t_sat;

	logic        out_valid_q;
	logic [31:0] o_t_q;
	logic [47:0] o_f_q;
	logic [30:0] o_m_q;
	logic [1:0]  o_s_q;

	// Handshake and range checks.
	always_comb begin
		acc = items.valid && items.ready;
		out_free = !out_valid_q || results.ready;
		node_ok = 32'(items.node) < 32'(MAX_NODES);
		peer_ok = 32'(items.peer_node) < 32'(MAX_NODES);
		elem_ok = 32'(items.element) < 32'(MAX_ELEMENTS);
		node_a = NAW'(items.node);
		peer_a = NAW'(items.peer_node);
		tm_ra = (items.cmd == CMD_DIFFUSE) ? peer_a : node_a;
	end
	assign items.ready = (state_q == S_IDLE);

	// A result word enters the output register when the sequencer finishes a read or advance.
	always_comb begin
		out_load = 1'b0;
		if (out_free) begin
			if (state_q == S_FIN) begin
				out_load = 1'b1;
			end
			if (state_q == S_EXEC && cmd_q != CMD_DIFFUSE &&
				!(cmd_q == CMD_ADVANCE && ok_q && m_rd != '0)) begin
				out_load = 1'b1;
			end
		end
	end

	// Stiffness memory, read at acceptance of a diffuse word.
	fheat_stiff_store #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_stiff (
		.clk(clk),
		.we(acc && items.cmd == CMD_LOAD_STIFF && elem_ok),
		.re(acc && items.cmd == CMD_DIFFUSE),
		.element(items.element),
		.local_row(items.local_row),
		.local_col(items.local_col),
		.wdata(items.value),
		.rdata(k_rd)
	);

	// Divider for time_step * |force| / mass.
	assign dctl.start = (state_q == S_DIVS);
	fheat_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(dctl),
		.dividend(p_q),
		.divisor(m_rd),
		.stat(dstat),
		.quotient(quo)
	);

	// Diffuse arithmetic: round the product, subtract, saturate to 48 bits.
	always_comb begin
		rnd = (prod_q + 64'sd32768) >>> 16;
		fsum = $signed({f_rd[47], f_rd}) - $signed({rnd[47], rnd[47:0]});
		if (fsum[48] != fsum[47]) begin
			f_new = fsum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			f_new = fsum[47:0];
		end
	end

	// Advance arithmetic: apply the signed step and saturate to 32 bits.
	always_comb begin
		qs = (quo[DIV_W-1:33] != '0) ? {1'b1, 33'd0} : {1'b0, quo[32:0]};
		if (f_rd[47]) begin
			tsum = 35'(t_rd) - $signed({1'b0, qs});
		end else begin
			tsum = 35'(t_rd) + $signed({1'b0, qs});
		end
		t_sat = (tsum[34:31] != 4'b0000) && (tsum[34:31] != 4'b1111);
		if (t_sat) begin
			t_new = tsum[34] ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			t_new = tsum[31:0];
		end
	end

	// Write ports of the node memories.
	always_comb begin
		tm_we = 1'b0;
		tm_wa = node_a;
		tm_wd = {items.value, items.mass_value};
		f_we = 1'b0;
		f_wa = node_a;
		f_wd = '0;
		if (acc && items.cmd == CMD_LOAD_NODE && node_ok) begin
			tm_we = 1'b1;
			f_we = 1'b1;
		end
		if (state_q == S_ACC) begin
			f_we = 1'b1;
			f_wa = node_q;
			f_wd = f_new;
		end
		if (state_q == S_FIN && out_free) begin
			tm_we = 1'b1;
			tm_wa = node_q;
			tm_wd = {t_new, m_rd};
			f_we = 1'b1;
			f_wa = node_q;
		end
	end

	// Node memories with registered reads.
	always_ff @(posedge clk) begin
		if (tm_we) begin
			tm_mem[tm_wa] <= tm_wd;
		end
		if (acc) begin
			{t_rd, m_rd} <= tm_mem[tm_ra];
		end
		if (f_we) begin
			f_mem[f_wa] <= f_wd;
		end
		if (acc) begin
			f_rd <= f_mem[node_a];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q <= items.cmd;
			node_q <= node_a;
		end
		if (state_q == S_EXEC) begin
			prod_q <= $signed(k_rd) * t_rd;
			mag_q <= f_rd[47] ? 48'(-f_rd) : f_rd;
		end
		if (state_q == S_MUL1) begin
			plo_q <= dt_q * mag_q[23:0];
		end
		if (state_q == S_MUL2) begin
			p_q <= DIV_W'(plo_q) + (DIV_W'(dt_q * mag_q[47:24]) << 24);
		end
	end

	// Sequencer, configuration register and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dt_q <= TIME_STEP_RESET;
			ok_q <= 1'b0;
			out_valid_q <= 1'b0;
			o_t_q <= '0;
			o_f_q <= '0;
			o_m_q <= '0;
			o_s_q <= ST_OK;
		end else begin
			if (cfg_we) begin
				dt_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						ok_q <= node_ok;
						case (items.cmd)
							CMD_DIFFUSE: begin
								if (node_ok && peer_ok && elem_ok) begin
									state_q <= S_EXEC;
								end
							end
							CMD_ADVANCE, CMD_READ: state_q <= S_EXEC;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_EXEC: begin
					if (cmd_q == CMD_DIFFUSE) begin
						state_q <= S_ACC;
					end else if (cmd_q == CMD_ADVANCE && ok_q && m_rd != '0) begin
						state_q <= S_MUL1;
					end else if (out_free) begin
						o_t_q <= ok_q ? t_rd : '0;
						o_f_q <= ok_q ? f_rd : '0;
						o_m_q <= ok_q ? m_rd : '0;
						o_s_q <= (ok_q && cmd_q == CMD_ADVANCE) ? ST_ZERO_MASS : ST_OK;
						state_q <= S_IDLE;
					end
				end
				S_ACC: state_q <= S_IDLE;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_DIVS;
				S_DIVS: state_q <= S_DIV;
				S_DIV: begin
					if (dstat.done || !dstat.busy) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						o_t_q <= t_new;
						o_f_q <= f_rd;
						o_m_q <= m_rd;
						o_s_q <= t_sat ? ST_SAT : ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign results.valid = out_valid_q;
	assign results.temperature = o_t_q;
	assign results.force_value = o_f_q;
	assign results.mass_out = o_m_q;
	assign results.status = o_s_q;
endmodule
